[design/quantized_step_sequencer_top_assert.svh]
// Assertion macros for the quantized step sequencer top level.
// Depends on nothing; included by quantized_step_sequencer_top.sv.
`ifndef QUANTIZED_STEP_SEQUENCER_TOP_ASSERT_SVH
`define QUANTIZED_STEP_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define QSS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define QSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/qss_pkg.sv]
// Package for the quantized step sequencer: payload, config types, codes,
// and the pitch quantizer tables. Depends on nothing.
package qss_pkg;

   // Fixed sizes of the block.
   localparam int TIMER_WIDTH         = 22;
   localparam int PERIOD_WIDTH        = 22;
   localparam int CMP_WIDTH           = (TIMER_WIDTH > PERIOD_WIDTH) ? TIMER_WIDTH
                                                                      : PERIOD_WIDTH;
   localparam int DAC_FULL_SCALE_CODE = 4095;
   localparam int REFERENCE_VOLTS     = 5;
   localparam int CV_MAX              = 4095;
   localparam int CV_DIVISOR          = 12 * REFERENCE_VOLTS;
   localparam int CSR_DATA_WIDTH      = 40;
   localparam int CV_TABLE_DEPTH      = 64;

   // Operation codes of an input item.
   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_JUMP = 2'd1,
      OP_STOP = 2'd2
   } qss_op_type;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_STEP_PERIOD  = 3'd0,
      CSR_GATE_LENGTH  = 3'd1,
      CSR_ROOT_NOTE    = 3'd2,
      CSR_SCALE_MINOR  = 3'd3,
      CSR_STEP_PITCHES = 3'd4,
      CSR_STEP_BEATS   = 3'd5
   } qss_csr_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [2:0] step_index;
   } qss_req_type;

   typedef struct packed {
      logic [11:0] cv_code;
      logic        gate;
      logic [2:0]  current_step;
      logic        beat_fired;
   } qss_rsp_type;

   typedef struct packed {
      logic [PERIOD_WIDTH-1:0] step_period_ticks;
      logic [PERIOD_WIDTH-1:0] gate_length_ticks;
      logic [3:0]              root_note;
      logic                    scale_minor;
      logic [39:0]             step_pitches;
      logic [23:0]             step_beats;
   } qss_cfg_type;

   // Scale degree to semitone tables.
   localparam logic [3:0] MAJOR_TAB [7] = '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11};
   localparam logic [3:0] MINOR_TAB [7] = '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10};

   typedef logic [11:0] cv_table_type [CV_TABLE_DEPTH];

   // Builds the code table for (24 + semitone) values at elaboration.
   function automatic cv_table_type build_cv_table();
      cv_table_type t;
      int           code;
      for (int v = 0; v < CV_TABLE_DEPTH; v++) begin
         code = (v * DAC_FULL_SCALE_CODE) / CV_DIVISOR;
         if (code > DAC_FULL_SCALE_CODE) code = DAC_FULL_SCALE_CODE;
         if (code > CV_MAX) code = CV_MAX;
         t[v] = 12'(code);
      end
      return t;
   endfunction

   localparam cv_table_type CV_TABLE = build_cv_table();

   // Quantizes one signed scale degree to a DAC code.
   function automatic logic [11:0] pitch_code(logic [4:0] raw, logic minor,
                                              logic [3:0] root);
      int         d;
      int         oct;
      int         deg;
      int         semi;
      logic [5:0] idx;
      d = int'($signed(raw));
      if (d < -12) d = -12;
      if (d > 12) d = 12;
      // Floor split into octave and degree without a divider.
      if (d < -7) oct = -2;
      else if (d < 0) oct = -1;
      else if (d < 7) oct = 0;
      else oct = 1;
      deg  = d - 7 * oct;
      semi = minor ? int'(MINOR_TAB[3'(deg)]) : int'(MAJOR_TAB[3'(deg)]);
      idx  = 6'(24 + semi + 12 * oct + int'(root));
      return CV_TABLE[idx];
   endfunction

endpackage

[design/qss_csr.sv]
// Configuration registers of the quantized step sequencer.
// Depends on qss_pkg.
module qss_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [2:0]                        csr_index,
   input  logic [qss_pkg::CSR_DATA_WIDTH-1:0] csr_wdata,
   output qss_pkg::qss_cfg_type              cfg
);
   import qss_pkg::*;

   qss_cfg_type cfg_ff;

   // Register writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_period_ticks <= PERIOD_WIDTH'(500000);
         cfg_ff.gate_length_ticks <= PERIOD_WIDTH'(250000);
         cfg_ff.root_note         <= '0;
         cfg_ff.scale_minor       <= 1'b0;
         cfg_ff.step_pitches      <= 40'd247132686368;
         cfg_ff.step_beats        <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_STEP_PERIOD:  cfg_ff.step_period_ticks <= csr_wdata[PERIOD_WIDTH-1:0];
            CSR_GATE_LENGTH:  cfg_ff.gate_length_ticks <= csr_wdata[PERIOD_WIDTH-1:0];
            CSR_ROOT_NOTE:    cfg_ff.root_note         <= csr_wdata[3:0];
            CSR_SCALE_MINOR:  cfg_ff.scale_minor       <= csr_wdata[0];
            CSR_STEP_PITCHES: cfg_ff.step_pitches      <= csr_wdata[39:0];
            CSR_STEP_BEATS:   cfg_ff.step_beats        <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/qss_in_reg.sv]
// Input register of the quantized step sequencer: holds one accepted item.
// Depends on qss_pkg.
module qss_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  qss_pkg::qss_req_type req_payload,
   input  logic                 advance,
   output logic                 item_valid,
   output qss_pkg::qss_req_type item
);
   import qss_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   qss_req_type item_ff;

   // Room exists when empty or when the held item moves on this cycle.
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload captures on every transfer.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_payload;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[design/qss_engine.sv]
// Sequencer state and next-result logic: tick counter, beat and step
// advance, gate timing and pitch quantization. Depends on qss_pkg.
module qss_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  qss_pkg::qss_req_type item,
   input  qss_pkg::qss_cfg_type cfg,
   output qss_pkg::qss_rsp_type result
);
   import qss_pkg::*;

   logic [TIMER_WIDTH-1:0] elapsed_ff;
   logic [TIMER_WIDTH-1:0] elapsed_in;
   logic [2:0]             step_ff;
   logic [2:0]             step_in;
   logic [2:0]             beat_ff;
   logic [2:0]             beat_in;
   logic                   gate_ff;
   logic                   gate_in;
   logic [11:0]            cv_ff;
   logic [11:0]            cv_in;
   logic                   fire;
   logic [TIMER_WIDTH-1:0] elapsed_inc;
   logic [2:0]             beat_field;

   // Saturating increment of the tick counter.
   assign elapsed_inc = (elapsed_ff == {TIMER_WIDTH{1'b1}}) ? elapsed_ff
                                                            : elapsed_ff + 1'b1;
   assign beat_field  = cfg.step_beats[step_ff*3 +: 3];

   // Next state for the item in the input register.
   always_comb begin
      elapsed_in = elapsed_ff;
      step_in    = step_ff;
      beat_in    = beat_ff;
      gate_in    = gate_ff;
      cv_in      = cv_ff;
      fire       = 1'b0;
      case (item.operation)
         OP_TICK: begin
            elapsed_in = elapsed_inc;
            if (CMP_WIDTH'(elapsed_inc) >= CMP_WIDTH'(cfg.step_period_ticks)) begin
               fire = 1'b1;
               // The step moves on once its beat total is reached.
               if (beat_ff >= beat_field) begin
                  step_in = step_ff + 3'd1;
                  beat_in = '0;
               end else begin
                  beat_in = beat_ff + 3'd1;
               end
               elapsed_in = '0;
               cv_in      = pitch_code(cfg.step_pitches[step_in*5 +: 5],
                                       cfg.scale_minor, cfg.root_note);
               gate_in    = 1'b1;
            end
            if (gate_in &&
                CMP_WIDTH'(elapsed_in) >= CMP_WIDTH'(cfg.gate_length_ticks)) begin
               gate_in = 1'b0;
            end
         end
         OP_JUMP: begin
            step_in = item.step_index;
         end
         OP_STOP: begin
            cv_in   = '0;
            gate_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         step_ff    <= '0;
         beat_ff    <= '0;
         gate_ff    <= 1'b0;
         cv_ff      <= '0;
      end else if (advance) begin
         elapsed_ff <= elapsed_in;
         step_ff    <= step_in;
         beat_ff    <= beat_in;
         gate_ff    <= gate_in;
         cv_ff      <= cv_in;
      end
   end

   assign result.cv_code      = cv_in;
   assign result.gate         = gate_in;
   assign result.current_step = step_in;
   assign result.beat_fired   = fire;

endmodule

[design/qss_out_reg.sv]
// Result register of the quantized step sequencer.
// Depends on qss_pkg.
module qss_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  qss_pkg::qss_rsp_type result,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output qss_pkg::qss_rsp_type rsp_payload
);
   import qss_pkg::*;

   logic        valid_ff;
   qss_rsp_type payload_ff;

   // A new result loads; a taken result without a successor empties it.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         payload_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

[design/quantized_step_sequencer_top.sv]
// Top level of the quantized step sequencer: register bank, input register,
// sequencer engine and result register. Depends on qss_pkg and the assert header.
//
//   channel   direction  handshake                  contents
//   req       in         req_valid / req_ready      operation, step_index
//   rsp       out        rsp_valid / rsp_ready      cv_code, gate, current_step, beat_fired
//   csr       in         csr_wr_en                  csr_index, csr_wdata
//
// One item per clock cycle is sustained while results are taken; an item passes
// through the input register, then the result register, which offers its result.
// The engine state updates as an item moves from input to result register.
// Synchronous reset empties both registers and loads the register defaults.
// With the result side stalled, one more item is held, then req_ready drops.
`include "quantized_step_sequencer_top_assert.svh"

module quantized_step_sequencer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  qss_pkg::qss_req_type              req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output qss_pkg::qss_rsp_type              rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [2:0]                        csr_index,
   input  logic [qss_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);
   import qss_pkg::*;

   qss_cfg_type cfg;
   qss_req_type item;
   qss_rsp_type result;
   logic        item_valid;
   logic        advance;

   // The held item moves on when the result register is free or being taken.
   assign advance = item_valid && (!rsp_valid || rsp_ready);

   qss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   qss_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .advance     (advance),
      .item_valid  (item_valid),
      .item        (item)
   );

   qss_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .cfg     (cfg),
      .result  (result)
   );

   qss_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .result      (result),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // A full input register facing a stalled result must refuse new items.
   `QSS_ASSERT_IMP(a_stall_blocks, clock, reset, item_valid && rsp_valid && !rsp_ready, !req_ready, "input accepted while both stages are full")

   // A fired beat reaches the result register on the next edge.
   `QSS_ASSERT_NEXT(a_beat_reaches_rsp, clock, reset, advance && result.beat_fired, rsp_valid && rsp_payload.beat_fired, "fired beat lost between engine and result")

   // A stop silences pitch and gate in its result.
   `QSS_ASSERT_NEXT(a_stop_silences, clock, reset, advance && item.operation == OP_STOP, rsp_payload.cv_code == '0 && !rsp_payload.gate, "stop did not silence outputs")

endmodule

[tb/testbench.sv]
// Self-checking testbench for the quantized step sequencer top level.
// Depends on qss_pkg and quantized_step_sequencer_top, which brings in its submodules.
`timescale 1ns / 100ps

module testbench;
   import qss_pkg::*;

   // Operation code that the block reports on without changing state.
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam logic [TIMER_WIDTH-1:0] TIMER_TOP      = '1;
   localparam int                     WATCHDOG_LIMIT = 1000;
   localparam int                     PHASE_ITEMS    = 172;
   localparam int                     PRESSURE_HOLD  = 60;

   // Semitone offsets of the seven scale degrees.
   localparam int MAJOR_SEMIS [7] = '{0, 2, 4, 5, 7, 9, 11};
   localparam int MINOR_SEMIS [7] = '{0, 2, 3, 5, 7, 8, 10};

   // Degrees beyond both saturation limits and at the octave boundaries.
   localparam logic [39:0] PITCH_EXTREMES =
      {5'h19, 5'h07, 5'h00, 5'h1F, 5'h0C, 5'h14, 5'h0F, 5'h10};

   localparam qss_req_type NO_ITEM  = '0;
   localparam qss_rsp_type ZERO_RSP = '0;

   // One row of the directed part: a register write or an item transfer.
   typedef struct packed {
      logic        is_write;
      qss_csr_type csr_sel;
      logic [39:0] value;
      qss_req_type item;
      logic        typed;
      qss_rsp_type want;
   } stim_row_type;

   localparam stim_row_type DIRECTED [32] = '{
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_TICK, 3'd0}, 1'b1, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_NONE, 3'd5}, 1'b1, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_JUMP, 3'd7}, 1'b1,
        '{12'd0, 1'b0, 3'd7, 1'b0}},
      '{1'b1, CSR_STEP_PERIOD, 40'd0, NO_ITEM, 1'b0, ZERO_RSP},
      '{1'b1, CSR_GATE_LENGTH, 40'd0, NO_ITEM, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_TICK, 3'd2}, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_TICK, 3'd5}, 1'b0, ZERO_RSP},
      '{1'b1, CSR_GATE_LENGTH, 40'h3FFFFF, NO_ITEM, 1'b0, ZERO_RSP},
      '{1'b1, CSR_STEP_PITCHES, PITCH_EXTREMES, NO_ITEM, 1'b0, ZERO_RSP},
      '{1'b1, CSR_ROOT_NOTE, 40'd15, NO_ITEM, 1'b0, ZERO_RSP},
      '{1'b1, CSR_SCALE_MINOR, 40'd1, NO_ITEM, 1'b0, ZERO_RSP},
      '{1'b1, CSR_STEP_BEATS, 40'hFFFFFF, NO_ITEM, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_TICK, 3'd1}, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_TICK, 3'd3}, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_TICK, 3'd4}, 1'b0, ZERO_RSP},
      '{1'b1, CSR_STEP_BEATS, 40'd0, NO_ITEM, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_TICK, 3'd0}, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_TICK, 3'd7}, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_TICK, 3'd1}, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_TICK, 3'd6}, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_TICK, 3'd2}, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_TICK, 3'd5}, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_TICK, 3'd3}, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_TICK, 3'd4}, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_STOP, 3'd7}, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_JUMP, 3'd3}, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_TICK, 3'd0}, 1'b0, ZERO_RSP},
      '{1'b1, CSR_ROOT_NOTE, 40'd0, NO_ITEM, 1'b0, ZERO_RSP},
      '{1'b1, CSR_SCALE_MINOR, 40'd0, NO_ITEM, 1'b0, ZERO_RSP},
      '{1'b1, CSR_STEP_PERIOD, 40'h3FFFFF, NO_ITEM, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_TICK, 3'd6}, 1'b0, ZERO_RSP},
      '{1'b0, CSR_STEP_PERIOD, 40'd0, '{OP_STOP, 3'd0}, 1'b0, ZERO_RSP}
   };

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   qss_req_type               req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   qss_rsp_type               rsp_payload;
   logic                      csr_wr_en   = 1'b0;
   logic [2:0]                csr_index   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata   = '0;

   // Register settings as the sequencer should see them.
   logic [21:0] cfg_period    = 22'd500000;
   logic [21:0] cfg_gate_len  = 22'd250000;
   logic [3:0]  cfg_root      = 4'd0;
   logic        cfg_minor     = 1'b0;
   logic [39:0] cfg_pitches   = 40'd247132686368;
   logic [23:0] cfg_beats     = 24'd0;

   // Sequencer state as predicted.
   logic [TIMER_WIDTH-1:0] seq_elapsed = '0;
   logic [2:0]             seq_step    = '0;
   logic [2:0]             seq_beat    = '0;
   logic                   seq_gate    = 1'b0;
   logic [11:0]            seq_cv      = '0;

   qss_rsp_type pending_outputs [$];
   int          mismatch_count = 0;
   int          send_idle_pct  = 0;
   int          recv_idle_pct  = 0;
   bit          hold_request   = 1'b0;
   int          hold_left      = 0;
   int          stall_cycles   = 0;

   quantized_step_sequencer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Quantizes one step's scale degree to the DAC code it should produce.
   function automatic logic [11:0] degree_to_code(input logic [2:0] step);
      logic [4:0] raw;
      int         d;
      int         oct;
      int         semis;
      int         code;
      raw = cfg_pitches[5*step +: 5];
      d   = $signed(raw);
      if (d < -12) d = -12;
      if (d > 12) d = 12;
      oct   = (d >= 0) ? d / 7 : -((-d + 6) / 7);
      semis = (cfg_minor ? MINOR_SEMIS[d - 7*oct] : MAJOR_SEMIS[d - 7*oct])
              + 12*oct + int'(cfg_root);
      code  = ((24 + semis) * DAC_FULL_SCALE_CODE) / CV_DIVISOR;
      if (code < 0) code = 0;
      if (code > DAC_FULL_SCALE_CODE) code = DAC_FULL_SCALE_CODE;
      if (code > CV_MAX) code = CV_MAX;
      return 12'(code);
   endfunction

   // Applies one item to the predicted state and returns the outputs it leaves.
   task automatic advance_sequencer(input qss_req_type item, output qss_rsp_type outcome);
      logic [3:0] beats_total;
      logic [3:0] next_beat;
      logic       fired;
      fired = 1'b0;
      case (item.operation)
         OP_TICK: begin
            if (seq_elapsed < TIMER_TOP) seq_elapsed = seq_elapsed + 1'b1;
            if (seq_elapsed >= cfg_period) begin
               beats_total = {1'b0, cfg_beats[3*seq_step +: 3]} + 4'd1;
               next_beat   = {1'b0, seq_beat} + 4'd1;
               // Greater-or-equal, so a beat count left over a jump still advances.
               if (next_beat >= beats_total) begin
                  seq_step  = seq_step + 3'd1;
                  next_beat = '0;
               end
               seq_beat    = next_beat[2:0];
               seq_elapsed = '0;
               seq_cv      = degree_to_code(seq_step);
               seq_gate    = 1'b1;
               fired       = 1'b1;
            end
            if (seq_gate && seq_elapsed >= cfg_gate_len) seq_gate = 1'b0;
         end
         OP_JUMP: seq_step = item.step_index;
         OP_STOP: begin
            seq_cv   = '0;
            seq_gate = 1'b0;
         end
         default: ;
      endcase
      outcome = '{seq_cv, seq_gate, seq_step, fired};
   endtask

   // Offers one item, waits for its transfer and records the outputs it must give.
   task automatic send_item(input qss_req_type item, input logic typed,
                            input qss_rsp_type want);
      qss_rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_sequencer(item, predicted);
      pending_outputs.push_back(typed ? want : predicted);
   endtask

   // Writes one register once every pending result has come back.
   task automatic write_csr(input qss_csr_type sel, input logic [39:0] value);
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (sel)
         CSR_STEP_PERIOD:  cfg_period   = value[21:0];
         CSR_GATE_LENGTH:  cfg_gate_len = value[21:0];
         CSR_ROOT_NOTE:    cfg_root     = value[3:0];
         CSR_SCALE_MINOR:  cfg_minor    = value[0];
         CSR_STEP_PITCHES: cfg_pitches  = value;
         CSR_STEP_BEATS:   cfg_beats    = value[23:0];
         default: ;
      endcase
   endtask

   // Result side: check each transfer, then choose the next ready level.
   always @(posedge clock) begin : rsp_side
      qss_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outputs.size() == 0) begin
               $error("result transfer with no expected output pending");
               mismatch_count++;
            end else begin
               want = pending_outputs.pop_front();
               if (rsp_payload.cv_code !== want.cv_code) begin
                  $error("cv_code: expected %0d, actual %0d", want.cv_code,
                         rsp_payload.cv_code);
                  mismatch_count++;
               end
               if (rsp_payload.gate !== want.gate) begin
                  $error("gate: expected %0d, actual %0d", want.gate, rsp_payload.gate);
                  mismatch_count++;
               end
               if (rsp_payload.current_step !== want.current_step) begin
                  $error("current_step: expected %0d, actual %0d", want.current_step,
                         rsp_payload.current_step);
                  mismatch_count++;
               end
               if (rsp_payload.beat_fired !== want.beat_fired) begin
                  $error("beat_fired: expected %0d, actual %0d", want.beat_fired,
                         rsp_payload.beat_fired);
                  mismatch_count++;
               end
            end
         end
         // A long hold-off lets the block fill up and stall its input.
         if (hold_request) begin
            hold_left    = PRESSURE_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Ends the run when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("[quantized_step_sequencer_top] ERROR");
         $finish;
      end
   end

   // Reset, directed table, then random phases under different idling patterns.
   initial begin
      qss_req_type item;
      logic [21:0] beat_period;
      logic [21:0] gate_len;
      int          roll;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DIRECTED); i++) begin
         if (DIRECTED[i].is_write) begin
            write_csr(DIRECTED[i].csr_sel, DIRECTED[i].value);
         end else begin
            send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
         end
      end

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               beat_period   = 22'd1;
               gate_len      = 22'd0;
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            1: begin
               beat_period   = 22'($urandom_range(6, 2));
               gate_len      = 22'($urandom_range(beat_period, 0));
               send_idle_pct = 48;
               recv_idle_pct = 0;
            end
            2: begin
               beat_period   = 22'd0;
               gate_len      = 22'($urandom_range(3, 0));
               send_idle_pct = 0;
               recv_idle_pct = 48;
            end
            3: begin
               beat_period   = 22'($urandom_range(12, 1));
               gate_len      = 22'h3FFFFF;
               send_idle_pct = 8;
               recv_idle_pct = 8;
            end
            4: begin
               beat_period   = 22'($urandom_range(4, 1));
               gate_len      = 22'($urandom_range(beat_period, 0));
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            default: begin
               beat_period   = 22'($urandom_range(9, 2));
               gate_len      = 22'd1;
               send_idle_pct = 48;
               recv_idle_pct = 48;
            end
         endcase
         write_csr(CSR_STEP_PERIOD, 40'(beat_period));
         write_csr(CSR_GATE_LENGTH, 40'(gate_len));
         write_csr(CSR_ROOT_NOTE, 40'($urandom_range(15, 0)));
         write_csr(CSR_SCALE_MINOR, 40'($urandom_range(1, 0)));
         write_csr(CSR_STEP_PITCHES, 40'({$urandom(), $urandom()}));
         write_csr(CSR_STEP_BEATS, 40'($urandom() & 32'hFFFFFF));
         if (phase == 4) hold_request = 1'b1;

         // Mostly ticks, with jumps, stops and the no-op code mixed in.
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(99, 0);
            if (roll < 80) item.operation = OP_TICK;
            else if (roll < 88) item.operation = OP_JUMP;
            else if (roll < 94) item.operation = OP_STOP;
            else item.operation = OP_NONE;
            item.step_index = 3'($urandom_range(7, 0));
            send_item(item, 1'b0, ZERO_RSP);
         end
      end

      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[quantized_step_sequencer_top] OK");
      end else begin
         $display("[quantized_step_sequencer_top] ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/qss_pkg.sv
design/qss_csr.sv
design/qss_in_reg.sv
design/qss_engine.sv
design/qss_out_reg.sv
design/quantized_step_sequencer_top.sv
tb/testbench.sv
